[rtl/ptg_pkg.sv]
// Shared constants and helper functions for the printable text generator.
// Used by ptg_word_ahead and printable_text_prng_generator_unit; no dependencies.
package ptg_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned COL_W = 7;
	localparam int unsigned POS_W = 3;
	localparam int unsigned CHAR_W = 7;

	localparam logic [COL_W-1:0] LINE_WIDTH = 7'd76;

	localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'h1234_5678_ABCD_EF01;
	localparam logic [WORD_W-1:0] STAR_MULT = 64'h2545_F491_4F6C_DD1D;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;
	localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 7'h20;
	localparam logic [CHAR_W-1:0] LAST_PRINTABLE = 7'h7E;
	localparam logic [7:0] PRINTABLE_SPAN = 8'd95;

	// Depth of the queue of words computed ahead of use.
	localparam int unsigned AHEAD_DEPTH = 4;
	localparam int unsigned AHEAD_AW = $clog2(AHEAD_DEPTH);
	localparam int unsigned AHEAD_CW = $clog2(AHEAD_DEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;

	// Status of the word-ahead unit as seen by the consumer.
	typedef struct packed {
		logic  valid;
		word_t word;
	} ahead_stat_t;

	// One xorshift64 state update with shifts 12, 25 and 27.
	function automatic word_t xorshift_step(input word_t s);
		word_t t;
		t = s ^ (s >> 12);
		t = t ^ (t << 25);
		t = t ^ (t >> 27);
		return t;
	endfunction

	// Reduce a byte modulo 95; a byte is below three times 95, so two compares suffice.
	function automatic logic [CHAR_W-1:0] byte_mod_span(input logic [7:0] b);
		logic [7:0] r;
		if (b < PRINTABLE_SPAN) begin
			r = b;
		end else if (b < 8'(2 * PRINTABLE_SPAN)) begin
			r = b - PRINTABLE_SPAN;
		end else begin
			r = b - 8'(2 * PRINTABLE_SPAN);
		end
		return r[CHAR_W-1:0];
	endfunction

endpackage

[rtl/ptg_word_ahead.sv]
// Runs the xorshift64* generator ahead of use and queues its output words.
// Depends on ptg_pkg for the state update, the multiplier constant and the queue depth.
module ptg_word_ahead (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 reload,
	input  ptg_pkg::word_t       seed,
	input  logic                 pop,
	output ptg_pkg::ahead_stat_t stat
);
	import ptg_pkg::*;

	word_t lead_q;
	word_t next_state;
	logic  issue;

	logic                 valid_s1;
	logic [2*HALF_W-1:0]  p_ll_s1;
	logic [HALF_W-1:0]    p_hl_s1;
	logic [HALF_W-1:0]    p_lh_s1;
	word_t                product;

	word_t               queue_q [AHEAD_DEPTH];
	logic [AHEAD_AW-1:0] wr_ptr_q;
	logic [AHEAD_AW-1:0] rd_ptr_q;
	logic [AHEAD_CW-1:0] count_q;
	logic                push;
	logic                do_pop;

	assign next_state = xorshift_step(lead_q);
	// Stage one holds at most one word in flight, so leave room for it.
	assign issue = (count_q + AHEAD_CW'(valid_s1)) < AHEAD_CW'(AHEAD_DEPTH);

	// Low 64 bits of the product from three 32x32 partial products.
	assign product = p_ll_s1 + {p_hl_s1 + p_lh_s1, {HALF_W{1'b0}}};
	assign push = valid_s1;
	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= DEFAULT_SEED;
			valid_s1 <= 1'b0;
		end else if (reload) begin
			lead_q <= (seed != '0) ? seed : DEFAULT_SEED;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				lead_q <= next_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			p_ll_s1 <= next_state[HALF_W-1:0] * STAR_MULT[HALF_W-1:0];
			p_hl_s1 <= HALF_W'(next_state[WORD_W-1:HALF_W] * STAR_MULT[HALF_W-1:0]);
			p_lh_s1 <= HALF_W'(next_state[HALF_W-1:0] * STAR_MULT[WORD_W-1:HALF_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !reload) begin
			queue_q[wr_ptr_q] <= product;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else if (reload) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign stat.valid = (count_q != '0);
	assign stat.word = queue_q[rd_ptr_q];

endmodule

[rtl/printable_text_prng_generator_unit.sv]
// Top level of the printable text generator: stream ports, line and position counters.
// Depends on ptg_pkg and ptg_word_ahead.

// The block emits one character beat for every input beat, one beat per clock
// cycle when the output side keeps taking them and a word is queued. Each input
// beat carries a single new_fill flag in s_tdata bit 0; a set flag restarts the
// line column and the 8-byte position before the character is made. After 76
// printable characters a newline is sent and m_tuser is high for that beat.
// Characters are the low byte of the current generator word modulo 95 plus 0x20;
// a fresh 64-bit word is taken on a printable character at position zero, and a
// word that runs dry after a newline yields spaces. The xorshift64* words come
// ahead of use from a two-stage multiplier pipeline feeding a four-word queue,
// so the rate is one byte per cycle. After reset or a seed write the queue
// refills; s_tready stays low until a word is queued. Writing the seed (cfg_wen
// with cfg_wdata) reloads the generator state and empties the queue, a zero seed
// selecting the fixed default; the counters and the partly used word are kept.
module printable_text_prng_generator_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [0] new_fill, [7:1] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,   // [6:0] text_byte, [7] zero
	output logic                   m_tuser,   // [0] line_break
	input  logic                   cfg_wen,
	input  logic [ptg_pkg::WORD_W-1:0] cfg_wdata
);
	import ptg_pkg::*;

	ahead_stat_t ahead;

	word_t            pending_q;
	logic [COL_W-1:0] column_q;
	logic [POS_W-1:0] position_q;

	logic             out_valid_q;
	logic [CHAR_W-1:0] text_byte_q;
	logic             line_break_q;

	logic             accept;
	logic             new_fill;
	logic [COL_W-1:0] col_eff;
	logic [POS_W-1:0] pos_eff;
	logic             is_break;
	logic             draw;
	word_t            cur_word;
	logic [CHAR_W-1:0] char_code;

	// The output register parts the two sides: a new beat is taken while the
	// previous result is being handed over. A queued word must be on hand,
	// whether or not this beat actually draws one.
	assign s_tready = (!out_valid_q || m_tready) && ahead.valid;
	assign accept = s_tvalid && s_tready;

	assign new_fill = s_tdata[0];
	assign col_eff = new_fill ? '0 : column_q;
	assign pos_eff = new_fill ? '0 : position_q;

	assign is_break = (col_eff >= LINE_WIDTH);
	assign draw = !is_break && (pos_eff == '0);
	assign cur_word = draw ? ahead.word : pending_q;
	assign char_code = FIRST_PRINTABLE + byte_mod_span(cur_word[7:0]);

	ptg_word_ahead u_ahead (
		.clk    (clk),
		.arst_n (arst_n),
		.reload (cfg_wen),
		.seed   (cfg_wdata),
		.pop    (accept && draw),
		.stat   (ahead)
	);

	// Line and position state advance once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			column_q <= '0;
			position_q <= '0;
		end else if (accept) begin
			position_q <= pos_eff + 1'b1;
			if (is_break) begin
				column_q <= '0;
			end else begin
				column_q <= col_eff + 1'b1;
				pending_q <= cur_word >> 8;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			text_byte_q <= is_break ? NEWLINE_CODE : char_code;
			line_break_q <= is_break;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, text_byte_q};
	assign m_tuser = line_break_q;

	// A beat that needs a fresh word must find one queued.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && draw) |-> ahead.valid)
		else $error("word drawn from an empty queue");

	// Newline beats carry the newline code and nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[CHAR_W-1:0] == NEWLINE_CODE))
		else $error("line break beat without newline code");

	// All other beats are printable characters.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> ((m_tdata[CHAR_W-1:0] >= FIRST_PRINTABLE) &&
		(m_tdata[CHAR_W-1:0] <= LAST_PRINTABLE)))
		else $error("character outside the printable range");

	// The column never runs past the line width, so a break is always taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		column_q <= LINE_WIDTH)
		else $error("column past line width");

endmodule
